// ----- src/brb_pkg.sv -----
// Package for the byte ring buffer: sizes, action, status and command codes,
// and the command record passed from the front end to the back end.
// No dependencies.
package brb_pkg;

  localparam int unsigned DEPTH    = 1024;              // power of two
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = 11;                // holds DEPTH itself
  localparam int unsigned MAX_RUN  = 64;
  localparam int unsigned RUN_W    = $clog2(MAX_RUN + 1);
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned AMT_W    = 11;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 24;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_SKIP  = 3'd3,
    ACT_CLEAR = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_LONG = 2'd3
  } status_e;

  // Classified request kind, as the back end sees it
  typedef enum logic [2:0] {
    K_WRITE,
    K_READ,
    K_PEEK,
    K_SKIP,
    K_CLEAR,
    K_NOP,
    K_LONG
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data;
    logic [AMT_W-1:0]   amount;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

endpackage

// ----- src/byte_ring_buffer_top.sv -----
// Byte ring buffer: circular byte store with read, peek, skip and clear.
// A single result is valid in the cycle after its request is taken; a read or
// peek run enters the run state, then reads its first byte from the store, then
// gives one byte per cycle unless the output stalls, as do single results; a
// run holds the back end until its last byte, as the store has one read port.
// Reset clears pointers, count and queue; store contents stay undefined.
module byte_ring_buffer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [brb_pkg::IN_DW-1:0]  s_axis_tdata,  // data_in[7:0], amount[18:8], zero above
  input  logic [brb_pkg::ACT_W-1:0]  s_axis_tuser,  // action[2:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [brb_pkg::OUT_DW-1:0] m_axis_tdata,  // data_out[7:0], status[9:8],
                                                    // stored[20:10], zero above
  output logic                       m_axis_tlast   // last
);
  import brb_pkg::*;

  logic q_full;
  logic push;
  cmd_t front_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  brb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  brb_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  brb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- src/brb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/brb_front.sv -----
// Front end: takes requests off the input stream and classifies them,
// including the run-length limit check. Depends on brb_pkg.
module brb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [brb_pkg::IN_DW-1:0] s_axis_tdata,   // data_in[7:0], amount[18:8]
  input  logic [brb_pkg::ACT_W-1:0] s_axis_tuser,   // action[2:0]
  input  logic                      q_full_i,
  output logic                      push_o,
  output brb_pkg::cmd_t             cmd_o
);
  import brb_pkg::*;

  logic [AMT_W-1:0] amount;
  logic             too_long;
  kind_e            kind;
  logic             seen_q;

  assign amount   = s_axis_tdata[BYTE_W +: AMT_W];
  assign too_long = amount > AMT_W'(MAX_RUN);

  always_comb begin
    unique case (action_e'(s_axis_tuser))
      ACT_WRITE: kind = K_WRITE;
      ACT_READ:  kind = too_long ? K_LONG : K_READ;
      ACT_PEEK:  kind = too_long ? K_LONG : K_PEEK;
      ACT_SKIP:  kind = K_SKIP;
      ACT_CLEAR: kind = K_CLEAR;
      default:   kind = K_NOP;
    endcase
  end

  assign s_axis_tready = ~q_full_i;
  assign push_o        = s_axis_tvalid & ~q_full_i;
  assign cmd_o         = '{kind: kind, data: s_axis_tdata[BYTE_W-1:0], amount: amount};

  // tracks whether any request has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push_o) begin
      seen_q <= 1'b1;
    end
  end

  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> s_axis_tready)
    else $error("front not ready before first request");

endmodule

// ----- src/brb_cmd_queue.sv -----
// Short command queue between front and back end.
// Depends on brb_pkg.
module brb_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  brb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output brb_pkg::cmd_t cmd_o
);
  import brb_pkg::*;

  cmd_t                entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d;
  logic [QPTR_W-1:0]   rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- src/brb_back.sv -----
// Back end: owns the pointers, the byte count and the byte store, carries out
// each command and drives the result register. Depends on brb_pkg, brb_ram.
module brb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  brb_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [brb_pkg::OUT_DW-1:0] m_axis_tdata,  // data_out[7:0], status[9:8],
                                                    // stored[20:10], zero above
  output logic                       m_axis_tlast   // last
);
  import brb_pkg::*;

  back_state_e        state_q, state_d;
  logic [ADDR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ADDR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [RUN_W-1:0]   run_left_q, run_left_d;
  logic [ADDR_W-1:0]  run_pos_q, run_pos_d;
  logic               run_consume_q, run_consume_d;

  logic               out_valid_q, out_valid_d;
  logic               out_from_ram_q, out_from_ram_d;
  status_e            out_status_q, out_status_d;
  logic [CNT_W-1:0]   out_stored_q, out_stored_d;
  logic               out_last_q, out_last_d;

  logic               out_ready;
  logic               take;
  logic               is_run;
  logic               too_few;
  logic               run_start;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;

  assign out_ready = ~out_valid_q | m_axis_tready;
  assign take      = (state_q == BK_IDLE) & cmd_valid_i & out_ready;
  assign is_run    = (cmd_i.kind == K_READ) | (cmd_i.kind == K_PEEK);
  assign too_few   = cmd_i.amount > count_q;
  assign run_start = take & is_run & ~too_few & (cmd_i.amount != '0);
  assign pop_o     = take;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (run_start) state_d = BK_RUN;
      BK_RUN:  if (out_ready && run_left_q == RUN_W'(1)) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and result register loading
  always_comb begin
    wr_ptr_d       = wr_ptr_q;
    rd_ptr_d       = rd_ptr_q;
    count_d        = count_q;
    run_left_d     = run_left_q;
    run_pos_d      = run_pos_q;
    run_consume_d  = run_consume_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_valid_d    = out_valid_q & ~m_axis_tready;
    out_from_ram_d = out_from_ram_q;
    out_status_d   = out_status_q;
    out_stored_d   = out_stored_q;
    out_last_d     = out_last_q;

    unique case (state_q)
      BK_IDLE: begin
        if (take && !run_start) begin
          out_valid_d    = 1'b1;
          out_from_ram_d = 1'b0;
          out_status_d   = ST_OK;
          out_stored_d   = count_q;
          out_last_d     = 1'b1;
          case (cmd_i.kind) inside
            K_WRITE: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                out_status_d = ST_FULL;
              end else begin
                ram_we       = 1'b1;
                wr_ptr_d     = wr_ptr_q + 1'b1;
                count_d      = count_q + 1'b1;
                out_stored_d = count_q + 1'b1;
              end
            end
            K_READ, K_PEEK: begin
              if (too_few) out_status_d = ST_FEW;   // zero-length run is plain ok
            end
            K_SKIP: begin
              if (too_few) begin
                out_status_d = ST_FEW;
              end else begin
                rd_ptr_d     = rd_ptr_q + cmd_i.amount[ADDR_W-1:0];
                count_d      = count_q - cmd_i.amount;
                out_stored_d = count_q - cmd_i.amount;
              end
            end
            K_CLEAR: begin
              wr_ptr_d     = '0;
              rd_ptr_d     = '0;
              count_d      = '0;
              out_stored_d = '0;
            end
            K_LONG:  out_status_d = ST_LONG;
            default: ;
          endcase
        end else if (run_start) begin
          run_left_d    = cmd_i.amount[RUN_W-1:0];
          run_pos_d     = rd_ptr_q;
          run_consume_d = cmd_i.kind == K_READ;
        end
      end
      BK_RUN: begin
        if (out_ready) begin
          ram_re         = 1'b1;
          run_pos_d      = run_pos_q + 1'b1;
          run_left_d     = run_left_q - 1'b1;
          out_valid_d    = 1'b1;
          out_from_ram_d = 1'b1;
          out_status_d   = ST_OK;
          out_last_d     = run_left_q == RUN_W'(1);
          if (run_consume_q) begin
            // a read consumes byte by byte, so stored counts down
            rd_ptr_d     = rd_ptr_q + 1'b1;
            count_d      = count_q - 1'b1;
            out_stored_d = count_q - 1'b1;
          end else begin
            out_stored_d = count_q;
          end
        end
      end
      default: ;
    endcase
  end

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (run_pos_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      run_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      run_left_q  <= run_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_pos_q      <= run_pos_d;
    run_consume_q  <= run_consume_d;
    out_from_ram_q <= out_from_ram_d;
    out_status_q   <= out_status_d;
    out_stored_q   <= out_stored_d;
    out_last_q     <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(OUT_DW - CNT_W - STAT_W - BYTE_W)'(0), out_stored_q,
                          out_status_q, out_from_ram_q ? ram_rdata : BYTE_W'(0)};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("byte count above depth");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[ADDR_W-1:0])
    else $error("pointers disagree with byte count");

endmodule
